// ----- design/plnk_pkg.sv -----
package plnk_pkg;

   localparam int POS_W = 12;
   localparam int VAL_W = 32;
   localparam int LEN_W = 9;

   typedef enum logic [1:0] {
      FUNC_GET    = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      func_type                  func;
      logic [POS_W-1:0]          position;
      logic signed [VAL_W-1:0]   item_value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VAL_W-1:0]   read_value;
      logic [LEN_W-1:0]          list_length;
   } rsp_type;

endpackage

// ----- design/positional_linked_list.sv -----
// Positional singly linked list over a pool of CAPACITY nodes.
// Request channel (req_valid / req_stall / req_word) carries func, a 1-based
// position and a value: get, insert before position, delete at position, clear.
// Response channel (rsp_valid / rsp_stall / rsp_word) returns one word per
// request: status, the value read or removed (zero otherwise) and the length.
// The walk follows one link per cycle through the single read port of the link
// memory.
// One request is in flight at a time; req_stall is high from acceptance until
// the response word has been loaded into the output register.
// Reset empties the list: links of nodes never allocated since
// reset or clear are derived from a fill mark, so no clearing pass is run.
// Clear works the same way.
// While rsp_stall is high the response word holds and the block waits to
// load the next one; it still accepts a request while a response is pending.
module positional_linked_list #(
   parameter int CAPACITY = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plnk_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plnk_pkg::rsp_type rsp_word
);
   import plnk_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int IDX_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (IDX_W > POS_W + 1) ? IDX_W : POS_W + 1;
   localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE, S_WALK, S_FETCH, S_UPDATE, S_LINK, S_DONE
   } state_type;

   state_type               state_ff;
   func_type                op_ff;
   logic [VAL_W-1:0]        val_ff;
   logic [IDX_W-1:0]        head_ff;
   logic [IDX_W-1:0]        free_ff;
   logic [IDX_W-1:0]        count_ff;
   logic [IDX_W-1:0]        fresh_ff;
   logic [IDX_W-1:0]        cur_ff;
   logic [IDX_W-1:0]        prev_ff;
   logic [POS_W-1:0]        left_ff;
   logic                    pend_ff;
   status_type              res_status_ff;
   logic signed [VAL_W-1:0] res_value_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_word_ff;

   logic [IDX_W-1:0]        link_mem [CAPACITY];
   logic [VAL_W-1:0]        value_mem [CAPACITY];
   logic [IDX_W-1:0]        link_q_ff;
   logic [AW-1:0]           rd_addr_ff;
   logic [VAL_W-1:0]        value_q_ff;

   logic                    link_re;
   logic [AW-1:0]           link_raddr;
   logic                    link_we;
   logic [AW-1:0]           link_waddr;
   logic [IDX_W-1:0]        link_wdata;
   logic                    value_re;
   logic                    value_we;

   logic [IDX_W-1:0]        rd_addr_ext;
   logic [IDX_W-1:0]        link_val;
   logic [IDX_W-1:0]        cur_eff;
   logic [CMP_W-1:0]        pos_ext;
   logic [CMP_W-1:0]        cnt_ext;
   logic                    pos_zero;
   logic                    bad_access;
   logic                    bad_insert;
   logic                    pool_full;

   // Nodes at or above the fill mark were never allocated: their link is index + 1.
   assign rd_addr_ext = IDX_W'(rd_addr_ff);
   assign link_val    = (rd_addr_ext >= fresh_ff) ? rd_addr_ext + IDX_W'(1) : link_q_ff;
   assign cur_eff     = pend_ff ? link_val : cur_ff;

   assign pos_ext    = CMP_W'(req_word.position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign pos_zero   = (req_word.position == '0);
   assign bad_access = pos_zero || (pos_ext > cnt_ext);
   assign bad_insert = pos_zero || (pos_ext > cnt_ext + CMP_W'(1));
   assign pool_full  = (count_ff >= NIL);

   always_comb begin
      link_re    = 1'b0;
      link_raddr = AW'(cur_eff);
      link_we    = 1'b0;
      link_waddr = AW'(cur_ff);
      link_wdata = free_ff;
      value_re   = 1'b0;
      value_we   = 1'b0;
      case (state_ff)
         S_WALK: begin
            link_re = (left_ff != '0);
         end
         S_FETCH: begin
            link_re    = 1'b1;
            link_raddr = (op_ff == FUNC_INSERT) ? AW'(free_ff) : AW'(cur_ff);
            value_re   = (op_ff != FUNC_INSERT);
         end
         S_UPDATE: begin
            if (op_ff == FUNC_INSERT) begin
               link_we    = 1'b1;
               link_waddr = AW'(free_ff);
               link_wdata = cur_ff;
               value_we   = 1'b1;
            end else if (op_ff == FUNC_DELETE && prev_ff != NIL) begin
               link_we    = 1'b1;
               link_waddr = AW'(prev_ff);
               link_wdata = link_val;
            end
         end
         S_LINK: begin
            if (op_ff == FUNC_INSERT) begin
               link_we    = (prev_ff != NIL);
               link_waddr = AW'(prev_ff);
               link_wdata = cur_ff;
            end else begin
               link_we    = 1'b1;
               link_waddr = AW'(cur_ff);
               link_wdata = free_ff;
            end
         end
         default: begin
            link_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_q_ff  <= link_mem[link_raddr];
         rd_addr_ff <= link_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[AW'(free_ff)] <= val_ff;
      end
      if (value_re) begin
         value_q_ff <= value_mem[AW'(cur_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         free_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff         <= req_word.func;
                  val_ff        <= req_word.item_value;
                  left_ff       <= req_word.position - POS_W'(1);
                  cur_ff        <= head_ff;
                  prev_ff       <= NIL;
                  pend_ff       <= 1'b0;
                  res_value_ff  <= '0;
                  res_status_ff <= ST_OK;
                  case (req_word.func)
                     FUNC_CLEAR: begin
                        head_ff  <= NIL;
                        free_ff  <= '0;
                        count_ff <= '0;
                        fresh_ff <= '0;
                        state_ff <= S_DONE;
                     end
                     FUNC_INSERT: begin
                        if (bad_insert) begin
                           res_status_ff <= ST_RANGE;
                           state_ff      <= S_DONE;
                        end else if (pool_full) begin
                           res_status_ff <= ST_FULL;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_WALK;
                        end
                     end
                     default: begin
                        if (bad_access) begin
                           res_status_ff <= ST_RANGE;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_WALK;
                        end
                     end
                  endcase
               end
            end
            S_WALK: begin
               // follow one link per cycle; prev trails the node whose link is in flight
               if (left_ff != '0) begin
                  prev_ff <= cur_eff;
                  pend_ff <= 1'b1;
                  left_ff <= left_ff - POS_W'(1);
               end else begin
                  cur_ff   <= cur_eff;
                  pend_ff  <= 1'b0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               case (op_ff)
                  FUNC_GET: begin
                     res_value_ff <= value_q_ff;
                     state_ff     <= S_DONE;
                  end
                  FUNC_DELETE: begin
                     res_value_ff <= value_q_ff;
                     if (prev_ff == NIL) begin
                        head_ff <= link_val;
                     end
                     state_ff <= S_LINK;
                  end
                  FUNC_INSERT: begin
                     // advance the fill mark when the allocated node was never used
                     if (free_ff == fresh_ff) begin
                        fresh_ff <= fresh_ff + IDX_W'(1);
                     end
                     free_ff  <= link_val;
                     cur_ff   <= free_ff;
                     state_ff <= S_LINK;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_LINK: begin
               if (op_ff == FUNC_INSERT) begin
                  if (prev_ff == NIL) begin
                     head_ff <= cur_ff;
                  end
                  count_ff <= count_ff + IDX_W'(1);
               end else begin
                  free_ff  <= cur_ff;
                  count_ff <= count_ff - IDX_W'(1);
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_word_ff.status      <= res_status_ff;
                  rsp_word_ff.read_value  <= res_value_ff;
                  rsp_word_ff.list_length <= LEN_W'(count_ff);
                  state_ff                <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- design/plnk_checker.sv -----
module plnk_checker #(
   parameter int CAPACITY = 256
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input plnk_pkg::rsp_type rsp_word
);
   import plnk_pkg::*;

   // no response word survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response changed");

   // one request at a time: stall rises right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted while one in flight");

   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_OK |-> rsp_word.read_value == '0)
      else $error("failed operation returned a value");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_FULL |-> rsp_word.list_length == LEN_W'(CAPACITY))
      else $error("pool full reported below capacity");

endmodule

bind positional_linked_list plnk_checker #(.CAPACITY(CAPACITY)) u_plnk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
